// ----- sv/kvte_pkg.sv -----
// ----------------------------------------------------------------------------
// kvte_pkg
// Types and constants shared by the key/value table with expiry.
// ----------------------------------------------------------------------------
package kvte_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned TTL_BITS   = 32;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [TIME_BITS-1:0]  stamp_t;
  typedef logic [TTL_BITS-1:0]   ttl_t;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_SWEEP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXPIRED   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    key_t   key;
    value_t value;
    stamp_t stamp;
    logic   has_ttl;
    ttl_t   ttl;
  } entry_t;

  // sequencer -> table
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   clr_en;
    idx_t   clr_addr;
    key_t   key;
    stamp_t now;
  } ctl_t;

  // table -> sequencer, one checked slot
  typedef struct packed {
    logic   vld;
    idx_t   idx;
    logic   valid;
    logic   hit;
    logic   expired;
    value_t value;
  } chk_t;

endpackage

// ----- sv/kvte_if.sv -----
// ----------------------------------------------------------------------------
// kvte_if
// Request and response channels of the key/value table with expiry.
// ----------------------------------------------------------------------------
interface kvte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] item_key;
  logic [63:0] item_value;
  logic        has_ttl;
  logic [31:0] ttl_ms;
  logic [47:0] now_ms;

  modport source (
    output valid, op, item_key, item_value, has_ttl, ttl_ms, now_ms,
    input  ready
  );
  modport sink (
    input  valid, op, item_key, item_value, has_ttl, ttl_ms, now_ms,
    output ready
  );
endinterface

interface kvte_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] read_value;

  modport source (
    output valid, status, read_value,
    input  ready
  );
  modport sink (
    input  valid, status, read_value,
    output ready
  );
endinterface

// ----- sv/kvte_store.sv -----
// ----------------------------------------------------------------------------
// kvte_store
// Entry memory, valid bits and the shared key match / expiry compare unit.
// ----------------------------------------------------------------------------
module kvte_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kvte_pkg::ctl_t ctl_i,
  output kvte_pkg::chk_t chk_o
);
  import kvte_pkg::*;

  entry_t             mem_q [ENTRIES];
  entry_t             rd_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_vld_q;
  logic               rd_valid_q;
  idx_t               rd_idx_q;
  stamp_t             age;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q       <= mem_q[ctl_i.rd_addr];
      rd_valid_q <= valid_q[ctl_i.rd_addr];
      rd_idx_q   <= ctl_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctl_i.rd_en;
      if (ctl_i.wr_en) begin
        valid_q[ctl_i.wr_addr] <= 1'b1;
      end
      if (ctl_i.clr_en) begin
        valid_q[ctl_i.clr_addr] <= 1'b0;
      end
    end
  end

  // age wraps modulo 2^48
  assign age = ctl_i.now - rd_q.stamp;

  always_comb begin
    chk_o.vld     = rd_vld_q;
    chk_o.idx     = rd_idx_q;
    chk_o.valid   = rd_valid_q;
    chk_o.hit     = rd_valid_q && (rd_q.key == ctl_i.key);
    chk_o.expired = rd_q.has_ttl && (age >= TIME_BITS'(rd_q.ttl));
    chk_o.value   = rd_q.value;
  end

endmodule

// ----- sv/kvte_ctrl.sv -----
// ----------------------------------------------------------------------------
// kvte_ctrl
// Scan sequencer: walks all slots (a sweep clears expired slots during the
// walk), then applies the operation and registers the result word.
// ----------------------------------------------------------------------------
module kvte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  kvte_req_if.sink       req_i,
  kvte_rsp_if.source     rsp_o,
  output kvte_pkg::ctl_t ctl_o,
  input  kvte_pkg::chk_t chk_i
);
  import kvte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e  state_q, state_d;
  cnt_t    cnt_q;
  op_e     op_q;
  key_t    key_q;
  value_t  val_q;
  logic    has_ttl_q;
  ttl_t    ttl_q;
  stamp_t  now_q;

  logic    found_q, found_exp_q, free_q;
  idx_t    found_idx_q, free_idx_q;
  value_t  found_val_q;

  logic        out_vld_q;
  status_e     status_q;
  logic [63:0] value_q;

  logic        accept, scan_issue, scan_end, fire;
  logic        scan_clr;
  logic        fin_wr, fin_clr;
  idx_t        fin_addr;
  status_e     res_status;
  logic [63:0] res_value;

  assign accept     = req_i.valid && req_i.ready;
  assign scan_issue = (state_q == S_SCAN) && (cnt_q < CNT_W'(ENTRIES));
  assign scan_end   = (state_q == S_SCAN) && !scan_issue;
  assign fire       = (state_q == S_FIN) && (!out_vld_q || rsp_o.ready);
  assign scan_clr   = (state_q == S_SCAN) && chk_i.vld && (op_q == OP_SWEEP)
                      && chk_i.valid && chk_i.expired;

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = value_q;

  always_comb begin
    res_status = ST_OK;
    res_value  = '0;
    fin_wr     = 1'b0;
    fin_clr    = 1'b0;
    fin_addr   = found_idx_q;
    case (op_q)
      OP_SET: begin
        if (found_q) begin
          fin_wr = 1'b1;
        end else if (free_q) begin
          fin_wr   = 1'b1;
          fin_addr = free_idx_q;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_GET: begin
        if (!found_q) begin
          res_status = ST_NOT_FOUND;
        end else if (found_exp_q) begin
          res_status = ST_EXPIRED;
          fin_clr    = 1'b1;
        end else begin
          res_value = 64'(found_val_q);
        end
      end
      OP_DELETE: begin
        if (!found_q) begin
          res_status = ST_NOT_FOUND;
        end else begin
          fin_clr = 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    ctl_o.rd_en           = scan_issue;
    ctl_o.rd_addr         = cnt_q[IDX_W-1:0];
    ctl_o.wr_en           = fire && fin_wr;
    ctl_o.wr_addr         = fin_addr;
    ctl_o.wr_data.key     = key_q;
    ctl_o.wr_data.value   = val_q;
    ctl_o.wr_data.stamp   = now_q;
    ctl_o.wr_data.has_ttl = has_ttl_q;
    ctl_o.wr_data.ttl     = ttl_q;
    ctl_o.clr_en          = scan_clr || (fire && fin_clr);
    ctl_o.clr_addr        = scan_clr ? chk_i.idx : fin_addr;
    ctl_o.key             = key_q;
    ctl_o.now             = now_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (scan_issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if ((state_q == S_SCAN) && chk_i.vld) begin
          if (chk_i.hit && !found_q) begin
            found_q <= 1'b1;
          end
          if (!chk_i.valid && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(req_i.op);
      key_q     <= req_i.item_key[KEY_BITS-1:0];
      val_q     <= req_i.item_value[VALUE_BITS-1:0];
      has_ttl_q <= req_i.has_ttl;
      ttl_q     <= req_i.ttl_ms;
      now_q     <= req_i.now_ms;
    end
    if ((state_q == S_SCAN) && chk_i.vld) begin
      if (chk_i.hit && !found_q) begin
        found_idx_q <= chk_i.idx;
        found_exp_q <= chk_i.expired;
        found_val_q <= chk_i.value;
      end
      if (!chk_i.valid && !free_q) begin
        free_idx_q <= chk_i.idx;
      end
    end
    if (fire) begin
      status_q <= res_status;
      value_q  <= res_value;
    end
  end

endmodule

// ----- sv/key_value_table_with_expiry_unit.sv -----
// ----------------------------------------------------------------------------
// key_value_table_with_expiry_unit
// Fixed-size key/value table with per-entry time-to-live expiry.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request word: op (set, get, delete, sweep), key,
//   value, has_ttl, ttl_ms and the current time now_ms. rsp_o returns one
//   word per request: status (ok, not found, expired, full) and read_value.
//   Every request scans all ENTRIES slots through one memory read port and
//   one shared key match / 48-bit age compare unit, one slot per cycle.
//   ready is low from acceptance until the response is registered, so the
//   block cannot take a new request before it is through with the last one.
//   The response sits in an output register: a new request is accepted
//   while it waits. If the receiver stalls with a response still pending,
//   the next request finishes its scan and holds until that word is taken.
//   Reset clears all valid bits at once; entry contents need no clearing.
// ----------------------------------------------------------------------------
module key_value_table_with_expiry_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvte_req_if.sink   req_i,
  kvte_rsp_if.source rsp_o
);
  import kvte_pkg::*;

  ctl_t ctl;
  chk_t chk;

  kvte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .ctl_o  (ctl),
    .chk_i  (chk)
  );

  kvte_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .chk_o  (chk)
  );

endmodule

// ----- sv/kvte_chk.sv -----
// ----------------------------------------------------------------------------
// kvte_chk
// Port-level checks for the key/value table with expiry.
// ----------------------------------------------------------------------------
module kvte_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [63:0] rsp_value_i
);
  import kvte_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_value_i))
    else $error("response word changed while stalled");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_value_i == 64'd0))
    else $error("nonzero read_value with non-ok status");

  a_busy_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i ##1 !req_ready_i)
    else $error("request taken during scan");

  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> req_ready_i)
    else $error("response raised while still busy");

endmodule

bind key_value_table_with_expiry_unit kvte_chk u_kvte_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_value_i  (rsp_o.read_value)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the key/value table with expiry against a cycle-free model of the
// table: set, get, delete and sweep with TTL ageing, time wrap and table-full,
// under random source idling, sink stalling and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  import kvte_pkg::*;

  typedef struct {
    op_e    op;
    key_t   key;
    value_t value;
    logic   has_ttl;
    ttl_t   ttl;
    stamp_t now;
  } req_word_t;

  typedef struct {
    status_e status;
    value_t  read_value;
  } rsp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kvte_req_if req_if ();
  kvte_rsp_if rsp_if ();

  key_value_table_with_expiry_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table contents as the block should hold them
  bit     tbl_valid   [ENTRIES];
  key_t   tbl_key     [ENTRIES];
  value_t tbl_value   [ENTRIES];
  stamp_t tbl_stamp   [ENTRIES];
  bit     tbl_has_ttl [ENTRIES];
  ttl_t   tbl_ttl     [ENTRIES];

  req_word_t req_q[$];
  rsp_word_t owed_rsp_q[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_go       = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned mismatches    = 0;

  key_t   key_pool[24];
  stamp_t clock_now;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic bit aged_out(int i, stamp_t now);
    stamp_t age;
    age = now - tbl_stamp[i];
    return tbl_has_ttl[i] && (age >= stamp_t'(tbl_ttl[i]));
  endfunction

  function automatic rsp_word_t apply_request(req_word_t w);
    rsp_word_t r;
    int        hit;
    int        slot;
    r.status     = ST_OK;
    r.read_value = '0;
    hit  = -1;
    slot = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == w.key) hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    case (w.op)
      OP_SET: begin
        if (hit >= 0) slot = hit;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[slot]   = 1'b1;
          tbl_key[slot]     = w.key;
          tbl_value[slot]   = w.value;
          tbl_stamp[slot]   = w.now;
          tbl_has_ttl[slot] = w.has_ttl;
          tbl_ttl[slot]     = w.ttl;
        end
      end
      OP_GET: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (aged_out(hit, w.now)) begin
          tbl_valid[hit] = 1'b0;
          r.status       = ST_EXPIRED;
        end else begin
          r.read_value = tbl_value[hit];
        end
      end
      OP_DELETE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else tbl_valid[hit] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_valid[i] && aged_out(i, w.now)) tbl_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic add_word(op_e op, key_t k, value_t v, logic ht, ttl_t t, stamp_t now);
    req_word_t w;
    w.op      = op;
    w.key     = k;
    w.value   = v;
    w.has_ttl = ht;
    w.ttl     = t;
    w.now     = now;
    req_q.push_back(w);
  endtask

  // mostly pool keys on a slowly advancing clock, some fill bursts, some noise
  task automatic add_random(int n);
    int   cnt;
    int   r;
    int   sel;
    op_e  op;
    ttl_t t;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 3) begin
        for (int j = 0; j < 18; j++) begin
          add_word(OP_SET, rand64(), rand64(), 1'b1, $urandom_range(60, 5), clock_now);
          clock_now += 1;
        end
        cnt += 18;
      end else if (r < 75) begin
        sel = $urandom_range(99);
        if (sel < 35) op = OP_SET;
        else if (sel < 70) op = OP_GET;
        else if (sel < 85) op = OP_DELETE;
        else op = OP_SWEEP;
        t = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(60);
        add_word(op, key_pool[$urandom_range(23)], rand64(), $urandom_range(99) < 60, t,
                 clock_now);
        cnt++;
      end else begin
        add_word(op_e'($urandom_range(3)), rand64(), rand64(), 1'($urandom_range(1)),
                 $urandom(), stamp_t'(rand64()));
        cnt++;
      end
      clock_now += $urandom_range(12);
    end
  endtask

  // request driver
  req_word_t offer;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        offer.op      = op_e'(req_if.op);
        offer.key     = req_if.item_key;
        offer.value   = req_if.item_value;
        offer.has_ttl = req_if.has_ttl;
        offer.ttl     = req_if.ttl_ms;
        offer.now     = req_if.now_ms;
        owed_rsp_q.push_back(apply_request(offer));
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offer = req_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.op         <= offer.op;
          req_if.item_key   <= offer.key;
          req_if.item_value <= offer.value;
          req_if.has_ttl    <= offer.has_ttl;
          req_if.ttl_ms     <= offer.ttl;
          req_if.now_ms     <= offer.now;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long sink hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // response monitor
  rsp_word_t due;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_rsp_q.size() == 0) begin
          $display("%0t: unexpected word, status %0d read_value %h", $time, rsp_if.status,
                   rsp_if.read_value);
          mismatches++;
        end else begin
          due = owed_rsp_q.pop_front();
          if (rsp_if.status !== due.status) begin
            $display("%0t: status expected %s got %0d", $time, due.status.name(),
                     rsp_if.status);
            mismatches++;
          end
          if (rsp_if.read_value !== due.read_value) begin
            $display("%0t: read_value expected %h got %h", $time, due.read_value,
                     rsp_if.read_value);
            mismatches++;
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    req_if.valid      = 1'b0;
    req_if.op         = OP_SET;
    req_if.item_key   = '0;
    req_if.item_value = '0;
    req_if.has_ttl    = 1'b0;
    req_if.ttl_ms     = '0;
    req_if.now_ms     = '0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_word(OP_GET, '0, rand64(), 1'b1, $urandom(), 48'd0);
    add_word(OP_DELETE, '1, rand64(), 1'b0, $urandom(), 48'd1);
    add_word(OP_SWEEP, rand64(), rand64(), 1'b1, $urandom(), '1);
    add_word(OP_SET, '0, '1, 1'b0, '1, 48'd0);
    add_word(OP_SET, '1, '0, 1'b1, '1, '1);
    add_word(OP_GET, '0, rand64(), 1'b0, '0, '1);
    add_word(OP_GET, '1, rand64(), 1'b1, '0, 48'd4);         // age across time wrap
    add_word(OP_SET, 64'h5, rand64(), 1'b1, '0, 48'd100);    // zero TTL
    add_word(OP_GET, 64'h5, rand64(), 1'b0, $urandom(), 48'd100);
    add_word(OP_GET, 64'h5, rand64(), 1'b1, $urandom(), 48'd101);
    add_word(OP_SET, 64'h6, 64'hA, 1'b1, 32'd10, 48'd1000);
    add_word(OP_SET, 64'h6, 64'hB, 1'b1, 32'd10, 48'd1002);  // overwrite in place
    add_word(OP_GET, 64'h6, rand64(), 1'b0, $urandom(), 48'd1011);
    add_word(OP_GET, 64'h6, rand64(), 1'b0, $urandom(), 48'd1012); // age equals TTL
    add_word(OP_SET, 64'h7, rand64(), 1'b1, 32'd10, 48'd1000);
    add_word(OP_DELETE, 64'h7, rand64(), 1'b1, $urandom(), 48'd2000); // expired delete
    add_word(OP_DELETE, 64'h7, rand64(), 1'b0, $urandom(), 48'd2001);
    add_word(OP_SET, 64'h8, rand64(), 1'b1, 32'd10, 48'd1000);
    add_word(OP_SET, 64'h8, 64'hC, 1'b0, $urandom(), 48'd2000); // restamp expired entry
    add_word(OP_SET, 64'h9, rand64(), 1'b1, 32'd1, 48'd3000);
    add_word(OP_SWEEP, rand64(), rand64(), 1'b0, '0, 48'd3001);
    add_word(OP_GET, 64'h9, rand64(), 1'b1, $urandom(), 48'd3002);
    add_word(OP_GET, 64'h8, rand64(), 1'b1, $urandom(), 48'd0);
    while (req_q.size() != 0) @(posedge clk_i);

    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    clock_now   = 48'hFFFF_FFFF_F000;

    add_random(110);
    while (req_q.size() != 0) @(posedge clk_i);
    src_idle_pct <= 59;
    add_random(110);
    while (req_q.size() != 0) @(posedge clk_i);
    src_idle_pct  <= 0;
    snk_stall_pct <= 59;
    add_random(110);
    while (req_q.size() != 0) @(posedge clk_i);
    src_idle_pct  <= 22;
    snk_stall_pct <= 22;
    add_random(110);
    while (req_q.size() != 0) @(posedge clk_i);
    src_idle_pct  <= 0;
    snk_stall_pct <= 0;
    hold_go       <= 1'b1;
    add_random(60);

    while (req_q.size() != 0 || req_if.valid || owed_rsp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
